// ===== rtl/core/fct_pkg.sv =====
// Package for the frustum culling test unit: plane register layout, opcodes
// and fixed widths shared by the channels and the pipeline modules.
// No dependencies.
`default_nettype none

package fct_pkg;

   localparam int NUM_PLANES     = 6;
   localparam int COEF_BITS      = 12;
   localparam int D_BITS         = 28;
   // a*x has 18 fraction bits, d has 8: d and the radius move up by 10
   localparam int SCALE_SHIFT    = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_SPHERE = 2'd1,
      OP_CUBE   = 2'd2,
      OP_BOX    = 2'd3
   } op_type;

   // Matches the 64-bit register image: d[63:36] c[35:24] b[23:12] a[11:0]
   typedef struct packed {
      logic signed [D_BITS-1:0]    d;
      logic signed [COEF_BITS-1:0] c;
      logic signed [COEF_BITS-1:0] b;
      logic signed [COEF_BITS-1:0] a;
   } plane_type;

endpackage

`default_nettype wire

// ===== rtl/core/fct_req_if.sv =====
// Request channel of the frustum culling test unit: one primitive per transfer.
// Depends on fct_pkg.
`default_nettype none

interface fct_req_if #(
   parameter int COORD_BITS = 24
);
   import fct_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic signed [COORD_BITS-1:0] x_a;
   logic signed [COORD_BITS-1:0] y_a;
   logic signed [COORD_BITS-1:0] z_a;
   logic signed [COORD_BITS-1:0] x_b;
   logic signed [COORD_BITS-1:0] y_b;
   logic signed [COORD_BITS-1:0] z_b;
   logic [COORD_BITS-2:0]        extent;

   modport source (
      output valid, op, x_a, y_a, z_a, x_b, y_b, z_b, extent,
      input  ready
   );
   modport sink (
      input  valid, op, x_a, y_a, z_a, x_b, y_b, z_b, extent,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/fct_rsp_if.sv =====
// Response channel of the frustum culling test unit: one inside flag per transfer.
// Depends on fct_pkg.
`default_nettype none

interface fct_rsp_if;
   import fct_pkg::*;

   logic valid;
   logic ready;
   logic inside_res;

   modport source (
      output valid, inside_res,
      input  ready
   );
   modport sink (
      input  valid, inside_res,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/fct_csr_if.sv =====
// Register write channel of the frustum culling test unit.
// Depends on fct_pkg.
`default_nettype none

interface fct_csr_if;
   import fct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/fct_plane_regs.sv =====
// Six plane coefficient registers written through the register channel.
// Depends on fct_pkg and fct_csr_if.
`default_nettype none

module fct_plane_regs (
   input  wire logic           clock,
   input  wire logic           reset,
   fct_csr_if.sink             csr_ch,
   output fct_pkg::plane_type  planes_ff [fct_pkg::NUM_PLANES]
);
   import fct_pkg::*;

   assign csr_ch.ready = 1'b1;

   // writes to an index past the last plane are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (reset) begin
            planes_ff[i] <= '0;
         end else if (csr_ch.valid && (csr_ch.index == CSR_INDEX_BITS'(i))) begin
            planes_ff[i] <= plane_type'(csr_ch.data);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fct_corner_stage.sv =====
// First pipeline stage: forms the two extreme corners per axis, which corner is
// larger, and the sphere radius bias. Depends on fct_pkg.
`default_nettype none

module fct_corner_stage #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [1:0]                   op,
   input  wire logic signed [COORD_BITS-1:0] x_a,
   input  wire logic signed [COORD_BITS-1:0] y_a,
   input  wire logic signed [COORD_BITS-1:0] z_a,
   input  wire logic signed [COORD_BITS-1:0] x_b,
   input  wire logic signed [COORD_BITS-1:0] y_b,
   input  wire logic signed [COORD_BITS-1:0] z_b,
   input  wire logic [COORD_BITS-2:0]        extent,
   output logic signed [COORD_BITS:0]        lo_ff    [3],
   output logic signed [COORD_BITS:0]        hi_ff    [3],
   output logic                              hi_ge_ff [3],
   output logic [COORD_BITS-2:0]             bias_ff
);
   import fct_pkg::*;

   localparam int CW = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] pa [3];
   logic signed [COORD_BITS-1:0] pb [3];
   logic signed [CW-1:0]         ext_w;
   logic signed [CW-1:0]         lo_in [3];
   logic signed [CW-1:0]         hi_in [3];
   logic                         hi_ge_in [3];
   logic [COORD_BITS-2:0]        bias_in;

   assign pa[0] = x_a;
   assign pa[1] = y_a;
   assign pa[2] = z_a;
   assign pb[0] = x_b;
   assign pb[1] = y_b;
   assign pb[2] = z_b;
   assign ext_w = signed'(CW'(extent));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (op_type'(op))
            OP_CUBE: begin
               lo_in[i]    = CW'(pa[i]) - ext_w;
               hi_in[i]    = CW'(pa[i]) + ext_w;
               hi_ge_in[i] = 1'b1;
            end
            OP_BOX: begin
               // corners taken as given, min and max may be swapped
               lo_in[i]    = CW'(pa[i]);
               hi_in[i]    = CW'(pb[i]);
               hi_ge_in[i] = (pb[i] >= pa[i]);
            end
            default: begin
               lo_in[i]    = CW'(pa[i]);
               hi_in[i]    = CW'(pa[i]);
               hi_ge_in[i] = 1'b1;
            end
         endcase
      end
      bias_in = (op_type'(op) == OP_SPHERE) ? extent : '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i]    <= lo_in[i];
            hi_ff[i]    <= hi_in[i];
            hi_ge_ff[i] <= hi_ge_in[i];
         end
         bias_ff <= bias_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fct_plane_eval.sv =====
// Per-plane distance pipeline: picks the corner farthest in front of the plane,
// multiplies, sums in two steps and flags a reject. Depends on fct_pkg.
`default_nettype none

module fct_plane_eval #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire fct_pkg::plane_type           plane,
   input  wire logic signed [COORD_BITS:0]   lo    [3],
   input  wire logic signed [COORD_BITS:0]   hi    [3],
   input  wire logic                         hi_ge [3],
   input  wire logic [COORD_BITS-2:0]        bias,
   output logic                              reject
);
   import fct_pkg::*;

   localparam int CW = COORD_BITS + 1;
   localparam int PW = CW + COEF_BITS;
   localparam int DW = D_BITS + SCALE_SHIFT;
   localparam int SW = ((PW > DW) ? PW : DW) + 3;

   logic signed [COEF_BITS-1:0] coef [3];
   logic signed [CW-1:0]        sel [3];
   logic signed [PW-1:0]        prod_in [3];
   logic signed [PW-1:0]        prod_ff [3];
   logic [COORD_BITS-2:0]       bias_ff;
   logic signed [SW-1:0]        sum_xy_in, sum_xy_ff;
   logic signed [SW-1:0]        sum_zd_in, sum_zd_ff;
   logic signed [SW-1:0]        sum_in, sum_ff;

   assign coef[0] = plane.a;
   assign coef[1] = plane.b;
   assign coef[2] = plane.c;

   // a*x grows with x for a >= 0, so the larger coordinate gives the max term
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sel[i]     = (hi_ge[i] ^ coef[i][COEF_BITS-1]) ? hi[i] : lo[i];
         prod_in[i] = PW'(coef[i]) * PW'(sel[i]);
      end
   end

   assign sum_xy_in = SW'(prod_ff[0]) + SW'(prod_ff[1]);
   assign sum_zd_in = SW'(prod_ff[2])
                    + (SW'(plane.d) <<< SCALE_SHIFT)
                    + signed'(SW'(bias_ff) << SCALE_SHIFT);
   assign sum_in    = sum_xy_ff + sum_zd_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         bias_ff   <= bias;
         sum_xy_ff <= sum_xy_in;
         sum_zd_ff <= sum_zd_in;
         sum_ff    <= sum_in;
      end
   end

   assign reject = sum_ff[SW-1] || (sum_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/frustum_culling_test_unit.sv =====
// Six-plane frustum culling test. Each request carries one point, sphere, cube or
// box and yields one inside flag. One request is taken every clock cycle unless the
// pipeline holds; the result passes five register stages (corners, products, two
// adder levels, result register). All stages hold when the result register is full
// and not taken, so request ready follows response ready. Plane registers are
// written through the register channel, never stall it, and reset to zero. Depends
// on fct_pkg, the channel interfaces, fct_plane_regs, fct_corner_stage and
// fct_plane_eval.
`default_nettype none

module frustum_culling_test_unit #(
   parameter int COORD_BITS = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fct_req_if.sink    req_ch,
   fct_rsp_if.source  rsp_ch,
   fct_csr_if.sink    csr_ch
);
   import fct_pkg::*;

   localparam int CW = COORD_BITS + 1;

   plane_type             planes_ff [NUM_PLANES];
   logic signed [CW-1:0]  lo_ff    [3];
   logic signed [CW-1:0]  hi_ff    [3];
   logic                  hi_ge_ff [3];
   logic [COORD_BITS-2:0] bias_ff;
   logic [NUM_PLANES-1:0] reject;

   logic enable;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic inside_ff;

   assign enable       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = enable;

   fct_plane_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .planes_ff (planes_ff)
   );

   fct_corner_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_corner (
      .clock    (clock),
      .enable   (enable),
      .op       (req_ch.op),
      .x_a      (req_ch.x_a),
      .y_a      (req_ch.y_a),
      .z_a      (req_ch.z_a),
      .x_b      (req_ch.x_b),
      .y_b      (req_ch.y_b),
      .z_b      (req_ch.z_b),
      .extent   (req_ch.extent),
      .lo_ff    (lo_ff),
      .hi_ff    (hi_ff),
      .hi_ge_ff (hi_ge_ff),
      .bias_ff  (bias_ff)
   );

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      fct_plane_eval #(
         .COORD_BITS (COORD_BITS)
      ) u_eval (
         .clock  (clock),
         .enable (enable),
         .plane  (planes_ff[p]),
         .lo     (lo_ff),
         .hi     (hi_ff),
         .hi_ge  (hi_ge_ff),
         .bias   (bias_ff),
         .reject (reject[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         v1_ff        <= req_ch.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         inside_ff <= ~|reject;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.inside_res = inside_ff;

endmodule

`default_nettype wire
